// File: design/lzss_stream_decoder_defines.svh
// ----------------------------------------------------------------------------
// lzss_stream_decoder_defines.svh
// Assertion macros shared by the decoder checks.
// ----------------------------------------------------------------------------
`ifndef LZSS_STREAM_DECODER_DEFINES_SVH
`define LZSS_STREAM_DECODER_DEFINES_SVH

// same-cycle implication, clocked on clk, off during reset
`define LZSS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define LZSS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/lzss_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lzss_pkg
// Shared types and constants for the LZSS stream decoder.
// ----------------------------------------------------------------------------
package lzss_pkg;

  localparam int BYTE_W   = 8;
  localparam int POS_W    = 12;  // absolute ring position in a reference
  localparam int LEN_W    = 5;   // copy length, up to 15 + 2
  localparam int CNT_W    = 24;
  localparam int STAT_W   = 2;
  localparam int IDX_W    = 4;
  localparam int OUT_TDATA_W = 40;  // 34 bits of fields padded to 5 bytes
  localparam int OUT_TUSER_W = 2;

  localparam logic [BYTE_W-1:0] SPACE_CHAR = 8'h20;
  localparam logic [IDX_W-1:0]  FLAG_SPAN  = 4'd8;
  localparam logic [CNT_W-1:0]  CAP_RESET  = 24'hFFFFFF;

  // token phase
  localparam logic [1:0] PH_FLAG  = 2'd0;
  localparam logic [1:0] PH_TOKEN = 2'd1;
  localparam logic [1:0] PH_REF   = 2'd2;

  // stream status
  localparam logic [STAT_W-1:0] ERR_NONE  = 2'd0;
  localparam logic [STAT_W-1:0] ERR_TRUNC = 2'd1;
  localparam logic [STAT_W-1:0] ERR_OVF   = 2'd2;

  typedef struct packed {
    logic accept;  // input transfer taken this cycle
    logic sub;     // fold copy position back into the ring
    logic issue;   // first ring read of a copy
    logic step;    // emit one copied byte, read the next
  } ctrl_cmd_t;

  typedef struct packed {
    logic can_emit;   // output register free or draining
    logic ref_ready;  // next byte completes a reference
    logic pos_big;    // copy position still at or beyond ring size
    logic copy_done;  // current copy step is the final one
  } dp_stat_t;

endpackage

// File: design/lzss_stream_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lzss_stream_decoder
// LZSS decoder with an absolute-position history ring, byte stream in/out.
// ----------------------------------------------------------------------------
// Flag bytes, literals and a reference's first byte are taken in the input state.
// A reference's second byte moves on to the read state, which folds RING_SIZE off
// a position at or above RING_SIZE and then starts the ring read; the copy state
// then emits each copied byte (2 to 17) through the one-read/one-write ring.
// Reset is synchronous: config returns to 0xFFFFFF, stream state to start.
// The ring is not swept: a fill count marks written entries, others read 0x20.
module lzss_stream_decoder #(
  parameter int RING_SIZE = 4096,
  parameter int LOOKAHEAD = 18,
  parameter int MIN_MATCH = 2
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [lzss_pkg::CNT_W-1:0]       cfg_wdata,   // out_capacity
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [lzss_pkg::BYTE_W-1:0]      s_tdata,     // [7:0] in_byte
  input  logic                             s_tlast,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [lzss_pkg::OUT_TDATA_W-1:0] m_tdata,     // [7:0] out_byte, [9:8] status,
                                                        // [33:10] total_count
  output logic                             m_tlast,     // run_last
  output logic [lzss_pkg::OUT_TUSER_W-1:0] m_tuser      // [0] has_byte, [1] stream_done
);
  import lzss_pkg::*;

  ctrl_cmd_t cmd;
  dp_stat_t  st;

  lzss_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .st       (st),
    .cmd      (cmd)
  );

  lzss_dpath #(
    .RING_SIZE (RING_SIZE),
    .LOOKAHEAD (LOOKAHEAD),
    .MIN_MATCH (MIN_MATCH)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .st        (st),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_byte   (s_tdata),
    .in_last   (s_tlast),
    .m_tready  (m_tready),
    .m_tvalid  (m_tvalid),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .m_tuser   (m_tuser)
  );

endmodule

// File: design/lzss_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lzss_ram
// Simple dual-port RAM, one write and one registered read, read-first.
// ----------------------------------------------------------------------------
module lzss_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: design/lzss_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lzss_ctrl
// Sequencer: takes input transfers, runs reference copies byte by byte.
// ----------------------------------------------------------------------------
module lzss_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  lzss_pkg::dp_stat_t  st,
  output lzss_pkg::ctrl_cmd_t cmd
);
  import lzss_pkg::*;

  localparam logic [1:0] ST_IN   = 2'd0;
  localparam logic [1:0] ST_RDC  = 2'd1;
  localparam logic [1:0] ST_COPY = 2'd2;

  logic [1:0] state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IN;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    s_tready   = 1'b0;
    state_next = state;
    unique case (state)
      ST_IN: begin
        s_tready = st.can_emit;
        if (s_tvalid && st.can_emit) begin
          cmd.accept = 1'b1;
          if (st.ref_ready) begin
            state_next = ST_RDC;
          end
        end
      end
      ST_RDC: begin
        if (st.pos_big) begin
          cmd.sub = 1'b1;
        end else begin
          cmd.issue  = 1'b1;
          state_next = ST_COPY;
        end
      end
      ST_COPY: begin
        if (st.can_emit) begin
          cmd.step = 1'b1;
          if (st.copy_done) begin
            state_next = ST_IN;
          end
        end
      end
      default: begin
        state_next = ST_IN;
      end
    endcase
  end

endmodule

// File: design/lzss_dpath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lzss_dpath
// Token decode, history ring, copy pointers, counters and output register.
// ----------------------------------------------------------------------------
module lzss_dpath #(
  parameter int RING_SIZE = 4096,
  parameter int LOOKAHEAD = 18,
  parameter int MIN_MATCH = 2
) (
  input  logic                                clk,
  input  logic                                rst,
  input  lzss_pkg::ctrl_cmd_t                 cmd,
  output lzss_pkg::dp_stat_t                  st,
  input  logic                                cfg_we,
  input  logic [lzss_pkg::CNT_W-1:0]          cfg_wdata,
  input  logic [lzss_pkg::BYTE_W-1:0]         in_byte,
  input  logic                                in_last,
  input  logic                                m_tready,
  output logic                                m_tvalid,
  output logic [lzss_pkg::OUT_TDATA_W-1:0]    m_tdata,
  output logic                                m_tlast,
  output logic [lzss_pkg::OUT_TUSER_W-1:0]    m_tuser
);
  import lzss_pkg::*;

  localparam int AW = $clog2(RING_SIZE);
  localparam logic [AW:0]   RSZ     = (AW+1)'(RING_SIZE);
  localparam logic [AW:0]   START   = (AW+1)'(RING_SIZE - LOOKAHEAD);
  localparam logic [AW-1:0] LAST_A  = AW'(RING_SIZE - 1);
  localparam logic [POS_W:0] RSZ_POS = (POS_W+1)'(RING_SIZE);

  // stream state
  logic [CNT_W-1:0]  cap;
  logic [BYTE_W-1:0] flags, flags_next;
  logic [IDX_W-1:0]  idx, idx_next;
  logic [1:0]        phase, phase_next;
  logic [BYTE_W-1:0] first, first_next;
  logic [CNT_W-1:0]  count, count_next;
  logic [STAT_W-1:0] err, err_next;
  logic [AW-1:0]     wp, wp_next;
  logic [AW:0]       fill, fill_next;

  // copy state
  logic [POS_W-1:0]  rp, rp_next;
  logic [LEN_W-1:0]  rem, rem_next;
  logic              last_hold, last_hold_next;
  logic              byp, byp_next;
  logic [BYTE_W-1:0] byp_data, byp_data_next;
  logic              rvld, rvld_next;

  // output register
  logic              o_valid;
  logic [BYTE_W-1:0] o_byte;
  logic              o_has, o_last, o_done;
  logic [STAT_W-1:0] o_status;
  logic [CNT_W-1:0]  o_total;

  // emit request
  logic              emit;
  logic [BYTE_W-1:0] e_byte;
  logic              e_has, e_last, e_done;
  logic [STAT_W-1:0] e_status;
  logic [CNT_W-1:0]  e_total;
  logic              restart;

  logic              ram_we, ram_re;
  logic [BYTE_W-1:0] ram_wdata, ram_q;

  logic [AW-1:0]     rp_a, rp_wrap, wp_inc;
  logic [AW:0]       rp_ext, rp_off, fill_inc;
  logic              in_window;
  logic [CNT_W-1:0]  count_inc;
  logic [IDX_W-1:0]  idx_inc;
  logic              cap_hit, ovf_now, final_byte;
  logic [BYTE_W-1:0] copy_byte;

  lzss_ram #(.WIDTH(BYTE_W), .DEPTH(RING_SIZE)) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wp),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (rp_a),
    .rdata (ram_q)
  );

  // Entries written since stream start form a window from START of
  // length fill; anything outside it still reads as a space.
  assign rp_a      = rp[AW-1:0];
  assign rp_ext    = {1'b0, rp_a};
  assign rp_off    = (rp_ext >= START) ? (rp_ext - START) : (rp_ext + RSZ - START);
  assign in_window = rp_off < fill;
  assign rp_wrap   = (rp_a == LAST_A) ? '0 : (rp_a + 1'b1);
  assign wp_inc    = (wp == LAST_A) ? '0 : (wp + 1'b1);
  assign fill_inc  = (fill == RSZ) ? fill : (fill + 1'b1);
  assign count_inc = count + 1'b1;
  assign idx_inc   = idx + 1'b1;
  assign cap_hit   = (count_inc == cap);
  assign ovf_now   = (count >= cap);
  assign final_byte = (rem == LEN_W'(1)) || cap_hit;
  assign copy_byte = byp ? byp_data : (rvld ? ram_q : SPACE_CHAR);

  assign st.can_emit  = !o_valid || m_tready;
  assign st.ref_ready = (phase == PH_REF) && (err == ERR_NONE);
  assign st.pos_big   = {1'b0, rp} >= RSZ_POS;
  assign st.copy_done = ovf_now || final_byte;

  always_comb begin
    flags_next     = flags;
    idx_next       = idx;
    phase_next     = phase;
    first_next     = first;
    count_next     = count;
    err_next       = err;
    wp_next        = wp;
    fill_next      = fill;
    rp_next        = rp;
    rem_next       = rem;
    last_hold_next = last_hold;
    byp_next       = byp;
    byp_data_next  = byp_data;
    rvld_next      = rvld;
    emit     = 1'b0;
    e_byte   = '0;
    e_has    = 1'b0;
    e_last   = 1'b1;
    e_done   = 1'b0;
    e_status = ERR_NONE;
    e_total  = '0;
    restart  = 1'b0;
    ram_we    = 1'b0;
    ram_wdata = copy_byte;
    ram_re    = 1'b0;

    if (cmd.accept) begin
      priority if (err != ERR_NONE) begin
        if (in_last) begin
          emit     = 1'b1;
          e_done   = 1'b1;
          e_status = err;
          restart  = 1'b1;
        end
      end else if (phase == PH_TOKEN && flags[idx[2:0]]) begin
        if (in_last) begin
          err_next = ERR_TRUNC;
          emit     = 1'b1;
          e_done   = 1'b1;
          e_status = ERR_TRUNC;
          restart  = 1'b1;
        end else begin
          first_next = in_byte;
          phase_next = PH_REF;
        end
      end else if (phase == PH_TOKEN) begin
        if (!ovf_now) begin
          emit       = 1'b1;
          e_byte     = in_byte;
          e_has      = 1'b1;
          e_done     = in_last;
          e_total    = in_last ? count_inc : '0;
          ram_we     = 1'b1;
          ram_wdata  = in_byte;
          wp_next    = wp_inc;
          fill_next  = fill_inc;
          count_next = count_inc;
        end else begin
          err_next = ERR_OVF;
          if (in_last) begin
            emit     = 1'b1;
            e_done   = 1'b1;
            e_status = ERR_OVF;
          end
        end
        if (idx_inc >= FLAG_SPAN) begin
          idx_next   = FLAG_SPAN;
          phase_next = PH_FLAG;
        end else begin
          idx_next = idx_inc;
        end
        restart = in_last;
      end else if (phase == PH_REF) begin
        rp_next        = {in_byte[3:0], first};
        rem_next       = LEN_W'(in_byte[7:4]) + LEN_W'(MIN_MATCH);
        last_hold_next = in_last;
      end else begin
        // flag byte; the unused phase code lands here too
        flags_next = in_byte;
        idx_next   = '0;
        phase_next = PH_TOKEN;
        if (in_last) begin
          emit    = 1'b1;
          e_done  = 1'b1;
          e_total = count;
          restart = 1'b1;
        end
      end
    end

    if (cmd.sub) begin
      rp_next = rp - POS_W'(RING_SIZE);
    end

    if (cmd.issue) begin
      ram_re    = 1'b1;
      byp_next  = 1'b0;
      rvld_next = in_window;
      rp_next   = POS_W'(rp_wrap);
    end

    if (cmd.step) begin
      if (ovf_now) begin
        err_next = ERR_OVF;
        if (last_hold) begin
          emit     = 1'b1;
          e_done   = 1'b1;
          e_status = ERR_OVF;
          restart  = 1'b1;
        end
      end else begin
        emit       = 1'b1;
        e_byte     = copy_byte;
        e_has      = 1'b1;
        e_last     = final_byte;
        ram_we     = 1'b1;
        wp_next    = wp_inc;
        fill_next  = fill_inc;
        count_next = count_inc;
        if (final_byte) begin
          if (rem != LEN_W'(1)) begin
            err_next = ERR_OVF;
          end
          if (last_hold) begin
            e_done   = 1'b1;
            e_status = (rem != LEN_W'(1)) ? ERR_OVF : ERR_NONE;
            e_total  = (rem != LEN_W'(1)) ? '0 : count_inc;
            restart  = 1'b1;
          end
        end else begin
          // next read; a hit on the address written now takes the new byte
          ram_re        = 1'b1;
          byp_next      = (rp_a == wp);
          byp_data_next = copy_byte;
          rvld_next     = in_window;
          rp_next       = POS_W'(rp_wrap);
          rem_next      = rem - 1'b1;
        end
      end
      if (st.copy_done) begin
        if (idx_inc >= FLAG_SPAN) begin
          idx_next   = FLAG_SPAN;
          phase_next = PH_FLAG;
        end else begin
          idx_next   = idx_inc;
          phase_next = PH_TOKEN;
        end
      end
    end

    if (restart) begin
      flags_next = '0;
      idx_next   = FLAG_SPAN;
      phase_next = PH_FLAG;
      first_next = '0;
      count_next = '0;
      err_next   = ERR_NONE;
      wp_next    = START[AW-1:0];
      fill_next  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cap       <= CAP_RESET;
      flags     <= '0;
      idx       <= FLAG_SPAN;
      phase     <= PH_FLAG;
      first     <= '0;
      count     <= '0;
      err       <= ERR_NONE;
      wp        <= START[AW-1:0];
      fill      <= '0;
      rp        <= '0;
      rem       <= '0;
      last_hold <= 1'b0;
      byp       <= 1'b0;
      rvld      <= 1'b0;
      o_valid   <= 1'b0;
    end else begin
      if (cfg_we) begin
        cap <= cfg_wdata;
      end
      flags     <= flags_next;
      idx       <= idx_next;
      phase     <= phase_next;
      first     <= first_next;
      count     <= count_next;
      err       <= err_next;
      wp        <= wp_next;
      fill      <= fill_next;
      rp        <= rp_next;
      rem       <= rem_next;
      last_hold <= last_hold_next;
      byp       <= byp_next;
      rvld      <= rvld_next;
      if (emit) begin
        o_valid <= 1'b1;
      end else if (m_tready) begin
        o_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    byp_data <= byp_data_next;
    if (emit) begin
      o_byte   <= e_byte;
      o_has    <= e_has;
      o_last   <= e_last;
      o_done   <= e_done;
      o_status <= e_status;
      o_total  <= e_total;
    end
  end

  assign m_tvalid = o_valid;
  assign m_tdata  = {(OUT_TDATA_W - CNT_W - STAT_W - BYTE_W)'(0), o_total, o_status, o_byte};
  assign m_tlast  = o_last;
  assign m_tuser  = {o_done, o_has};

endmodule

// File: design/lzss_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lzss_checker
// Port-level checks on the decoder's result stream.
// ----------------------------------------------------------------------------
`include "lzss_stream_decoder_defines.svh"

module lzss_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             m_tvalid,
  input logic                             m_tready,
  input logic [lzss_pkg::OUT_TDATA_W-1:0] m_tdata,
  input logic                             m_tlast,
  input logic [lzss_pkg::OUT_TUSER_W-1:0] m_tuser
);

  // stalled transfer keeps its payload
  `LZSS_ASSERT_NEXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast), "output changed while stalled")
  // empty result carries a zero byte
  `LZSS_ASSERT_NOW(a_empty_zero, m_tvalid && !m_tuser[0], m_tdata[7:0] == 8'd0, "empty result with nonzero byte")
  // stream end is always the last result of its input transfer
  `LZSS_ASSERT_NOW(a_done_last, m_tvalid && m_tuser[1], m_tlast, "stream_done without run_last")
  // status and count only on stream end
  `LZSS_ASSERT_NOW(a_status_quiet, m_tvalid && !m_tuser[1], m_tdata[33:8] == 26'd0, "status or count outside stream end")
  // error reports no count, and no undefined code
  `LZSS_ASSERT_NOW(a_err_count, m_tvalid && m_tdata[9:8] != 2'd0, m_tdata[9:8] != 2'd3 && m_tdata[33:10] == 24'd0, "bad error report")

endmodule

bind lzss_stream_decoder lzss_checker u_lzss_checker (.*);

// File: verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for lzss_stream_decoder. Compressed streams (directed
// corner cases, then random token streams and noise) are pushed through the
// input stream port. A local decoder predicts every output transfer, and each
// output transfer is checked against the oldest prediction. The capacity
// register and the idle/stall patterns change between phases.
// ----------------------------------------------------------------------------
module tb;
  import lzss_pkg::*;

  localparam int RING_SIZE  = 4096;
  localparam int LOOKAHEAD  = 18;
  localparam int MIN_MATCH  = 2;
  localparam int SETTLE     = 40;      // > longest copy of one reference
  localparam int CYCLE_CAP  = 400000;
  localparam int PHASE_LEN  = 58;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       drain;  // hold off until all decoded bytes are out
  } in_item_t;

  typedef struct packed {
    logic [7:0]       out_byte;
    logic             has_byte;
    logic             run_last;
    logic             stream_done;
    logic [STAT_W-1:0] status;
    logic [CNT_W-1:0]  total_count;
  } dec_res_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_we = 1'b0;
  logic [CNT_W-1:0]       cfg_wdata = '0;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [BYTE_W-1:0]      s_tdata = '0;   // [7:0] in_byte
  logic                   s_tlast = 1'b0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;        // [7:0] out_byte, [9:8] status,
                                          // [33:10] total_count
  logic                   m_tlast;        // run_last
  logic [OUT_TUSER_W-1:0] m_tuser;        // [0] has_byte, [1] stream_done

  lzss_stream_decoder #(
    .RING_SIZE(RING_SIZE),
    .LOOKAHEAD(LOOKAHEAD),
    .MIN_MATCH(MIN_MATCH)
  ) DUT (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // decoder state mirror
  // --------------------------------------------------------------------------
  logic [7:0]        hist [RING_SIZE];
  int unsigned       wr_ptr;
  logic [7:0]        flag_reg;
  int unsigned       tok_slot;
  logic [1:0]        tok_phase;
  logic [7:0]        ref_lo;
  logic [CNT_W-1:0]  byte_count;
  logic [STAT_W-1:0] err_code;
  logic [CNT_W-1:0]  capacity;

  dec_res_t decoded_q [$];   // predicted output transfers, oldest first
  dec_res_t step_res [$];    // results of the byte being decoded
  in_item_t stream_q [$];    // input transfers waiting for the driver

  int  fail_count = 0;
  int  src_idle_pct = 0;
  int  sink_stall_pct = 0;
  bit  drain_next = 1'b0;

  function automatic void restart_stream();
    for (int i = 0; i < RING_SIZE; i++) hist[i] = SPACE_CHAR;
    wr_ptr     = (RING_SIZE - LOOKAHEAD) % RING_SIZE;
    flag_reg   = '0;
    tok_slot   = FLAG_SPAN;
    tok_phase  = PH_FLAG;
    ref_lo     = '0;
    byte_count = '0;
    err_code   = ERR_NONE;
  endfunction

  // returns 0 when the capacity would be exceeded
  function automatic bit emit_byte(input logic [7:0] c);
    dec_res_t r;
    if (byte_count >= capacity) begin
      err_code = ERR_OVF;
      return 1'b0;
    end
    r = '0;
    r.out_byte = c;
    r.has_byte = 1'b1;
    step_res.push_back(r);
    hist[wr_ptr] = c;
    wr_ptr = (wr_ptr + 1) % RING_SIZE;
    byte_count = byte_count + 1'b1;
    return 1'b1;
  endfunction

  function automatic void next_token();
    tok_slot++;
    if (tok_slot >= FLAG_SPAN) begin
      tok_slot = FLAG_SPAN;
      tok_phase = PH_FLAG;
    end
  endfunction

  function automatic void decode_byte(input logic [7:0] b, input logic last);
    dec_res_t    r;
    int unsigned pos;
    int unsigned len;
    step_res.delete();
    if (err_code == ERR_NONE) begin
      case (tok_phase)
        PH_TOKEN: begin
          if (flag_reg[tok_slot[2:0]]) begin
            if (last) begin
              err_code = ERR_TRUNC;
            end else begin
              ref_lo = b;
              tok_phase = PH_REF;
            end
          end else begin
            void'(emit_byte(b));
            next_token();
          end
        end
        PH_REF: begin
          pos = {b[3:0], ref_lo};
          len = b[7:4] + MIN_MATCH;
          for (int k = 0; k < len; k++) begin
            if (!emit_byte(hist[(pos + k) % RING_SIZE])) break;
          end
          tok_phase = PH_TOKEN;
          next_token();
        end
        default: begin
          flag_reg = b;
          tok_slot = 0;
          tok_phase = PH_TOKEN;
        end
      endcase
    end
    if (last) begin
      if (step_res.size() == 0) begin
        r = '0;
        step_res.push_back(r);
      end
      r = step_res.pop_back();
      r.stream_done = 1'b1;
      r.status = err_code;
      r.total_count = (err_code == ERR_NONE) ? byte_count : '0;
      step_res.push_back(r);
      restart_stream();
    end
    if (step_res.size() > 0) begin
      r = step_res.pop_back();
      r.run_last = 1'b1;
      step_res.push_back(r);
    end
    foreach (step_res[i]) decoded_q.push_back(step_res[i]);
  endfunction

  // --------------------------------------------------------------------------
  // driver
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    in_item_t nxt;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) decode_byte(s_tdata, s_tlast);
      if (!s_tvalid || s_tready) begin
        if (stream_q.size() == 0 || $urandom_range(0, 99) < src_idle_pct ||
            (stream_q[0].drain && (s_tvalid || decoded_q.size() != 0))) begin
          s_tvalid <= 1'b0;
        end else begin
          nxt = stream_q.pop_front();
          s_tvalid <= 1'b1;
          s_tdata  <= nxt.data;
          s_tlast  <= nxt.last;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // monitor
  // --------------------------------------------------------------------------
  function automatic void check_field(input string name, input longint want,
                                      input longint got);
    if (want != got) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin
    dec_res_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (decoded_q.size() == 0) begin
          $error("output transfer with nothing expected: tdata 0x%0h tuser 0x%0h",
                 m_tdata, m_tuser);
          fail_count++;
        end else begin
          want = decoded_q.pop_front();
          check_field("out_byte", want.out_byte, m_tdata[7:0]);
          check_field("has_byte", want.has_byte, m_tuser[0]);
          check_field("run_last", want.run_last, m_tlast);
          check_field("stream_done", want.stream_done, m_tuser[1]);
          check_field("status", want.status, m_tdata[9:8]);
          check_field("total_count", want.total_count, m_tdata[33:10]);
        end
      end
      m_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
    end
  end

  // --------------------------------------------------------------------------
  // watchdog
  // --------------------------------------------------------------------------
  int cycles = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_CAP) begin
      $display("tb failed");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // stimulus
  // --------------------------------------------------------------------------
  int queued;

  function automatic void add(input logic [7:0] d, input logic l);
    in_item_t it;
    it.data  = d;
    it.last  = l;
    it.drain = drain_next;
    drain_next = 1'b0;
    stream_q.push_back(it);
    queued++;
  endfunction

  function automatic void add_ref(input logic last_lo);
    logic [11:0] pos;
    logic [3:0]  len_f;
    // half the refs point near the start pointer, where recent bytes live
    pos = $urandom_range(0, 1) ? 12'(RING_SIZE - LOOKAHEAD + $urandom_range(0, 80))
                               : 12'($urandom);
    len_f = 4'($urandom);
    add(pos[7:0], last_lo);
    if (!last_lo) add({len_f, pos[11:8]}, 1'b0);
  endfunction

  // well-formed stream; end_kind 0/1 on a token, 2 on an extra byte,
  // 3 truncated in a reference
  function automatic void add_stream(input int ntok);
    int          end_kind;
    int          t;
    logic [7:0]  flags;
    in_item_t    it;
    end_kind = $urandom_range(0, 3);
    t = 0;
    while (t < ntok) begin
      flags = 8'($urandom);
      if (end_kind == 3 && ntok - 1 - t < 8) flags[ntok - 1 - t] = 1'b1;
      add(flags, 1'b0);
      for (int j = 0; j < 8 && t < ntok; j++) begin
        if (flags[j]) add_ref(end_kind == 3 && t == ntok - 1);
        else add(8'($urandom), 1'b0);
        t++;
      end
    end
    if (end_kind == 2) begin
      add(8'($urandom), 1'b1);
    end else begin
      it = stream_q.pop_back();
      it.last = 1'b1;
      stream_q.push_back(it);
    end
  endfunction

  function automatic void add_noise();
    int n;
    n = $urandom_range(1, 12);
    for (int i = 0; i < n; i++)
      add(8'($urandom), (i == n - 1) || ($urandom_range(0, 5) == 0));
  endfunction

  task automatic wait_quiet();
    while (stream_q.size() != 0 || s_tvalid || decoded_q.size() != 0)
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [CNT_W-1:0] v);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    capacity  = v;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  initial begin
    capacity = CAP_RESET;
    restart_stream();
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed: flag byte as last byte
    add(8'h00, 1'b1);
    // two literals at the byte extremes
    add(8'h00, 1'b0); add(8'h00, 1'b0); add(8'hFF, 1'b1);
    // literal, then overlapping copy from the start pointer (run of 'A'),
    // then a copy that wraps off the ring end
    add(8'h06, 1'b0); add(8'h41, 1'b0);
    add(8'hEE, 1'b0); add(8'hFF, 1'b0);
    add(8'hFF, 1'b0); add(8'h0F, 1'b1);
    // copy of untouched spaces at position zero, after a full drain
    drain_next = 1'b1;
    add(8'h01, 1'b0); add(8'h00, 1'b0); add(8'h00, 1'b1);
    // reference cut off after its first byte
    add(8'h01, 1'b0); add(8'h12, 1'b1);
    // eight literals, then the next flag byte ends the stream
    add(8'h00, 1'b0);
    for (int i = 0; i < 8; i++) add(8'(8'h80 + i), 1'b0);
    add(8'h01, 1'b1);
    wait_quiet();

    for (int ph = 1; ph <= 6; ph++) begin
      case (ph)
        1: write_capacity('0);
        2: write_capacity(CNT_W'(25));
        3: write_capacity(CNT_W'($urandom_range(1, 200)));
        4: write_capacity(CAP_RESET);
        5: write_capacity(CNT_W'($urandom_range(40, 120)));
        default: write_capacity(CAP_RESET - CNT_W'($urandom_range(0, 255)));
      endcase
      case (ph % 4)
        0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
        1: begin src_idle_pct = 54; sink_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  sink_stall_pct = 54; end
        default: begin src_idle_pct = 33; sink_stall_pct = 33; end
      endcase
      queued = 0;
      while (queued < PHASE_LEN) begin
        drain_next = ($urandom_range(0, 11) == 0);
        if ($urandom_range(0, 9) == 0) add_noise();
        else add_stream(($urandom_range(0, 7) == 0) ? $urandom_range(13, 40)
                                                     : $urandom_range(1, 12));
      end
      wait_quiet();
    end

    if (fail_count == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
